// File: hw/rtl/rtsch_pkg.sv
// ----------------------------------------------------------------------------
// rtsch_pkg
// Shared types and constants for the random tie-break event scheduler.
// ----------------------------------------------------------------------------
package rtsch_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ACTOR_BITS  = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TIME_W      = 64;
  localparam int SEQ_W       = 32;
  localparam int ENTRY_W     = TIME_W + ACTOR_BITS + SEQ_W;

  localparam logic [63:0] GOLDEN_SEED = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] STAR_MULT   = 64'd2685821657736338717;
  localparam int SHIFT_A = 12;
  localparam int SHIFT_B = 25;
  localparam int SHIFT_C = 27;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_STEP     = 2'd1,
    CMD_ADVANCE  = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  // One stored event.
  typedef struct packed {
    logic [TIME_W-1:0]     due;
    logic [ACTOR_BITS-1:0] actor;
    logic [SEQ_W-1:0]      seq;
  } entry_t;

endpackage

// File: hw/rtl/rtsch_ram.sv
// ----------------------------------------------------------------------------
// rtsch_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rtsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rtsch_draw.sv
// ----------------------------------------------------------------------------
// rtsch_draw
// Xorshift64* generator with a bit-serial multiplier and a bit-serial
// remainder by the tie count. Reports whether the draw modulo ties is zero.
// ----------------------------------------------------------------------------
module rtsch_draw (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      seed_we,
  input  logic [63:0]               seed_wdata,
  input  logic                      start,
  input  logic [rtsch_pkg::CNT_W-1:0] ties,
  output logic                      done,
  output logic                      hit
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_MOD  = 3'b100
  } dstate_t;

  dstate_t state;
  logic [63:0] gen;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [63:0] mconst;
  logic [5:0]  cnt;
  logic [rtsch_pkg::CNT_W-1:0] rem;
  logic [rtsch_pkg::CNT_W-1:0] ties_q;
  logic [63:0] xs1, xs2, xs3;
  logic [rtsch_pkg::CNT_W-1:0] trial;

  // One xorshift step on the current state.
  always_comb begin
    xs1 = gen ^ (gen >> rtsch_pkg::SHIFT_A);
    xs2 = xs1 ^ (xs1 << rtsch_pkg::SHIFT_B);
    xs3 = xs2 ^ (xs2 >> rtsch_pkg::SHIFT_C);
  end

  // Remainder trial: shift in the next dividend bit.
  assign trial = {rem[rtsch_pkg::CNT_W-2:0], acc[63]};

  // Sequencer: a bit-serial multiply phase, then a bit-serial remainder phase.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
      gen   <= rtsch_pkg::GOLDEN_SEED;
      hit   <= 1'b0;
    end else begin
      if (seed_we) begin
        gen <= (seed_wdata == 64'd0) ? rtsch_pkg::GOLDEN_SEED : seed_wdata;
      end
      unique case (state)
        D_IDLE: begin
          if (start) begin
            gen    <= xs3;
            mcand  <= xs3;
            mconst <= rtsch_pkg::STAR_MULT;
            acc    <= 64'd0;
            ties_q <= ties;
            cnt    <= 6'd0;
            state  <= D_MUL;
          end
        end
        D_MUL: begin
          if (mconst[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mconst <= mconst >> 1;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            rem   <= '0;
            state <= D_MOD;
          end
        end
        D_MOD: begin
          acc <= acc << 1;
          rem <= (trial >= ties_q) ? trial - ties_q : trial;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            hit   <= (((trial >= ties_q) ? trial - ties_q : trial) == '0);
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  // A start is only issued to an idle unit.
  property p_start_idle;
    @(posedge clk) disable iff (rst) start |-> state == D_IDLE;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("draw started while busy");

  // Done comes out of the remainder phase.
  property p_done_src;
    @(posedge clk) disable iff (rst) done |-> $past(state) == D_MOD;
  endproperty
  a_done_src: assert property (p_done_src) else $error("done without remainder phase");

  // Tie count is never zero while dividing.
  property p_ties_nz;
    @(posedge clk) disable iff (rst) state == D_MOD |-> ties_q != '0;
  endproperty
  a_ties_nz: assert property (p_ties_nz) else $error("zero divisor");

endmodule

// File: hw/rtl/random_tiebreak_event_scheduler_core.sv
// ----------------------------------------------------------------------------
// random_tiebreak_event_scheduler_core
// Virtual-time event queue: schedule, step with random tie-break, advance.
// ----------------------------------------------------------------------------
//   channel  | handshake            | word
//   in       | in_valid / in_stall  | cmd, actor, delay
//   out      | out_valid / out_stall| accepted .. queued_count
//   seed     | seed_we              | seed_wdata
// Schedule, advance and empty step go straight to the output state and wait there.
// A step reads and compares each of the n entries in turn, runs the bit-serial
// multiply and remainder of the draw unit per tie, then refills the served slot.
// Reset (rst, synchronous) empties the queue; the entry RAM needs no clearing.
// in_stall is high from acceptance until the result word is taken.
// ----------------------------------------------------------------------------
module random_tiebreak_event_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [63:0] seed_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] actor,
  input  logic [63:0] delay,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [15:0] served_actor,
  output logic [63:0] due_time,
  output logic [31:0] order_number,
  output logic [63:0] current_time,
  output logic [6:0]  queued_count
);

  localparam int IW = rtsch_pkg::IDX_W;
  localparam int CW = rtsch_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_WAIT = 7'b0001000,
    S_LRD  = 7'b0010000,
    S_LWR  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [63:0]   vtime;
  logic [31:0]   next_order;
  logic [CW-1:0] idx;
  logic [IW-1:0] best_idx;
  logic [CW-1:0] ties;
  rtsch_pkg::entry_t best, cand, rd_entry, wr_entry;
  logic [rtsch_pkg::ENTRY_W-1:0] rdata;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic          draw_start, draw_done, draw_hit;
  logic [64:0]   sum;
  logic          in_acc;

  assign rd_entry  = rdata;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign sum       = {1'b0, vtime} + {1'b0, delay};

  // Entry RAM port control.
  always_comb begin
    we       = 1'b0;
    waddr    = count[IW-1:0];
    wr_entry = '{due: sum[63:0], actor: actor[rtsch_pkg::ACTOR_BITS-1:0], seq: next_order};
    raddr    = idx[IW-1:0];
    if (state == S_IDLE) begin
      we = in_acc && (cmd == rtsch_pkg::CMD_SCHEDULE) && !sum[64]
           && (count < CW'(rtsch_pkg::QUEUE_DEPTH));
    end else if (state == S_LWR) begin
      we       = 1'b1;
      waddr    = best_idx;
      wr_entry = rd_entry;
    end
    if (state == S_LRD) begin
      raddr = IW'(count - CW'(1));
    end
  end

  rtsch_ram #(.WIDTH(rtsch_pkg::ENTRY_W), .DEPTH(rtsch_pkg::QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_entry), .raddr(raddr), .rdata(rdata)
  );

  assign draw_start = (state == S_CMP) && (idx != '0) && (rd_entry.due == best.due);

  rtsch_draw u_draw (
    .clk(clk), .rst(rst), .seed_we(seed_we), .seed_wdata(seed_wdata),
    .start(draw_start), .ties(ties + CW'(1)), .done(draw_done), .hit(draw_hit)
  );

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      vtime      <= 64'd0;
      next_order <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            accepted     <= 1'b0;
            served_actor <= 16'd0;
            due_time     <= 64'd0;
            order_number <= 32'd0;
            current_time <= vtime;
            queued_count <= 7'(count);
            state        <= S_OUT;
            case (cmd)
              rtsch_pkg::CMD_SCHEDULE: begin
                if (!sum[64]) begin
                  due_time     <= sum[63:0];
                  order_number <= next_order;
                  next_order   <= next_order + 32'd1;
                  if (count < CW'(rtsch_pkg::QUEUE_DEPTH)) begin
                    count        <= count + CW'(1);
                    queued_count <= 7'(count + CW'(1));
                    accepted     <= 1'b1;
                  end
                end
              end
              rtsch_pkg::CMD_STEP: begin
                if (count != '0) begin
                  idx   <= '0;
                  state <= S_RD;
                end
              end
              rtsch_pkg::CMD_ADVANCE: begin
                accepted     <= !sum[64];
                vtime        <= sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
                current_time <= sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
              end
              default: ;
            endcase
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          cand <= rd_entry;
          if (idx == '0 || rd_entry.due < best.due) begin
            best     <= rd_entry;
            best_idx <= idx[IW-1:0];
            ties     <= CW'(1);
          end else if (rd_entry.due == best.due) begin
            ties <= ties + CW'(1);
          end
          if (draw_start) begin
            state <= S_WAIT;
          end else if (idx + CW'(1) == count) begin
            state <= S_LRD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_RD;
          end
        end
        S_WAIT: begin
          if (draw_done) begin
            if (draw_hit) begin
              best     <= cand;
              best_idx <= idx[IW-1:0];
            end
            if (idx + CW'(1) == count) begin
              state <= S_LRD;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_RD;
            end
          end
        end
        S_LRD: state <= S_LWR;
        S_LWR: begin
          accepted     <= 1'b1;
          served_actor <= 16'(best.actor);
          due_time     <= best.due;
          order_number <= best.seq;
          count        <= count - CW'(1);
          queued_count <= 7'(count - CW'(1));
          if (best.due > vtime) begin
            vtime <= best.due;
          end
          current_time <= (best.due > vtime) ? best.due : vtime;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill count never exceeds the queue depth.
  property p_count_max;
    @(posedge clk) disable iff (rst) count <= CW'(rtsch_pkg::QUEUE_DEPTH);
  endproperty
  a_count_max: assert property (p_count_max) else $error("queue overfilled");

  // A refill write happens only with a nonempty queue.
  property p_refill;
    @(posedge clk) disable iff (rst) state == S_LWR |-> count != '0;
  endproperty
  a_refill: assert property (p_refill) else $error("refill on empty queue");

  // Virtual time never moves backward during a step.
  property p_time_mono;
    @(posedge clk) disable iff (rst) $past(state) == S_LWR |-> vtime >= $past(vtime);
  endproperty
  a_time_mono: assert property (p_time_mono) else $error("time moved backward");

endmodule
